// ===== rtl/lens_distortion_projection_macros.svh =====
// Assertion macros for the lens distortion projection block.
// Used by modules that carry concurrent checks; expects clk and rst in scope.
`ifndef LENS_DISTORTION_PROJECTION_MACROS_SVH
`define LENS_DISTORTION_PROJECTION_MACROS_SVH

// Same-cycle implication check.
`define LDP_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ldp check failed");

// Next-cycle implication check.
`define LDP_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ldp check failed");

`endif

// ===== rtl/ldp_pkg.sv =====
// Shared types, register indexes and fixed-point helpers for the projection block.
// No dependencies; used by every module of the block.
package ldp_pkg;

  typedef logic signed [31:0] q_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_K1 = 3'd0;
  localparam logic [2:0] REG_K2 = 3'd1;
  localparam logic [2:0] REG_P1 = 3'd2;
  localparam logic [2:0] REG_P2 = 3'd3;
  localparam logic [2:0] REG_FX = 3'd4;
  localparam logic [2:0] REG_FY = 3'd5;
  localparam logic [2:0] REG_CX = 3'd6;
  localparam logic [2:0] REG_CY = 3'd7;

  localparam q_t Q_ONE   = 32'sd268435456;
  localparam q_t S32_MAX = 32'sh7FFFFFFF;
  localparam q_t S32_MIN = 32'sh80000000;

  // Flags that ride along with each transaction.
  typedef struct packed {
    logic ovf;
    logic zero;
    logic sx;
    logic sy;
  } meta_t;

  typedef struct packed {
    logic ovf;
    q_t   val;
  } sat_t;

  // Normalized coordinates leaving the divider.
  typedef struct packed {
    q_t    xn;
    q_t    yn;
    meta_t meta;
  } div_out_t;

  // Distorted normalized coordinates.
  typedef struct packed {
    q_t    dx;
    q_t    dy;
    meta_t meta;
  } dist_out_t;

  // Saturate a wide signed value to 32 bits.
  function automatic sat_t sat32(input logic signed [53:0] v);
    sat_t r;
    if (v > 54'sd2147483647) begin
      r.ovf = 1'b1;
      r.val = S32_MAX;
    end else if (v < -54'sd2147483648) begin
      r.ovf = 1'b1;
      r.val = S32_MIN;
    end else begin
      r.ovf = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

  // Round a Q4.28 product to nearest, ties up, then saturate.
  function automatic sat_t rnd_sat(input logic signed [63:0] p);
    logic signed [63:0] s;
    logic signed [35:0] r;
    s = p + 64'sd134217728;
    r = s[63:28];
    return sat32(54'(r));
  endfunction

endpackage

// ===== rtl/ldp_divider.sv =====
// Pipelined restoring divider: forms x*2^28/z and y*2^28/z, one quotient bit per stage.
// Depends on ldp_pkg.
module ldp_divider (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_vld,
  input  ldp_pkg::q_t         wx,
  input  ldp_pkg::q_t         wy,
  input  ldp_pkg::q_t         wz,
  output logic                out_vld,
  output ldp_pkg::div_out_t   dout
);

  localparam int Steps = 32;

  typedef struct packed {
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] qx;
    logic [31:0] qy;
    logic [31:0] lx;
    logic [31:0] ly;
    logic [31:0] dz;
    logic        nx;
    logic        ny;
    logic        ox;
    logic        oy;
    logic        zero;
    logic        sx;
    logic        sy;
  } dst_t;

  typedef struct packed {
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] az;
    logic        nx;
    logic        ny;
    logic        zero;
    logic        sx;
    logic        sy;
  } dabs_t;

  // One restoring step on a remainder, its next dividend bit and the divisor.
  function automatic logic [32:0] div_step(input logic [31:0] rem, input logic bit_in,
                                           input logic [31:0] d);
    logic [32:0] t;
    logic [32:0] diff;
    t    = {rem, bit_in};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) return {1'b1, diff[31:0]};
    return {1'b0, t[31:0]};
  endfunction

  // Advance both lanes of one stage by a quotient bit.
  function automatic dst_t next_stage(input dst_t p);
    dst_t        n;
    logic [32:0] sxr;
    logic [32:0] syr;
    sxr  = div_step(p.rx, p.lx[31], p.dz);
    syr  = div_step(p.ry, p.ly[31], p.dz);
    n    = p;
    n.rx = sxr[31:0];
    n.ry = syr[31:0];
    n.qx = {p.qx[30:0], sxr[32]};
    n.qy = {p.qy[30:0], syr[32]};
    n.lx = {p.lx[30:0], 1'b0};
    n.ly = {p.ly[30:0], 1'b0};
    return n;
  endfunction

  // Final sign and saturation of a quotient magnitude.
  function automatic ldp_pkg::sat_t div_fix(input logic [31:0] q, input logic neg,
                                            input logic ovr);
    ldp_pkg::sat_t r;
    logic [31:0] nq;
    nq = ~q + 32'd1;
    if (ovr) begin
      r.ovf = 1'b1;
      r.val = neg ? ldp_pkg::S32_MIN : ldp_pkg::S32_MAX;
    end else if (neg) begin
      r.ovf = q > 32'h80000000;
      r.val = r.ovf ? ldp_pkg::S32_MIN : $signed(nq);
    end else begin
      r.ovf = q[31];
      r.val = r.ovf ? ldp_pkg::S32_MAX : $signed(q);
    end
    return r;
  endfunction

  dabs_t        s0;
  dst_t         st0;
  dst_t         pipe [1:Steps];
  logic [Steps:0] vld;
  ldp_pkg::sat_t fx;
  ldp_pkg::sat_t fy;

  // Input stage: magnitudes and quotient signs.
  always_ff @(posedge clk) begin
    if (adv) begin
      s0.ax   <= wx[31] ? (~wx + 32'd1) : wx;
      s0.ay   <= wy[31] ? (~wy + 32'd1) : wy;
      s0.az   <= wz[31] ? (~wz + 32'd1) : wz;
      s0.nx   <= wx[31] ^ wz[31];
      s0.ny   <= wy[31] ^ wz[31];
      s0.zero <= (wz == '0);
      s0.sx   <= wx[31];
      s0.sy   <= wy[31];
    end
  end

  // Seed of the bit loop; a quotient of 2^32 or more is flagged up front.
  always_comb begin
    st0.rx   = {4'd0, s0.ax[31:4]};
    st0.ry   = {4'd0, s0.ay[31:4]};
    st0.lx   = {s0.ax[3:0], 28'd0};
    st0.ly   = {s0.ay[3:0], 28'd0};
    st0.qx   = '0;
    st0.qy   = '0;
    st0.dz   = s0.az;
    st0.nx   = s0.nx;
    st0.ny   = s0.ny;
    st0.ox   = {4'd0, s0.ax[31:4]} >= s0.az;
    st0.oy   = {4'd0, s0.ay[31:4]} >= s0.az;
    st0.zero = s0.zero;
    st0.sx   = s0.sx;
    st0.sy   = s0.sy;
  end

  // One quotient bit per stage for each lane.
  always_ff @(posedge clk) begin
    if (adv) begin
      pipe[1] <= next_stage(st0);
      for (int k = 2; k <= Steps; k++) begin
        pipe[k] <= next_stage(pipe[k-1]);
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else if (adv) begin
      vld     <= {vld[Steps-1:0], in_vld};
      out_vld <= vld[Steps];
    end
  end

  // Output stage: sign, saturation and flags.
  always_comb begin
    fx = div_fix(pipe[Steps].qx, pipe[Steps].nx, pipe[Steps].ox);
    fy = div_fix(pipe[Steps].qy, pipe[Steps].ny, pipe[Steps].oy);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dout.xn        <= fx.val;
      dout.yn        <= fy.val;
      dout.meta.ovf  <= fx.ovf | fy.ovf | pipe[Steps].zero;
      dout.meta.zero <= pipe[Steps].zero;
      dout.meta.sx   <= pipe[Steps].sx;
      dout.meta.sy   <= pipe[Steps].sy;
    end
  end

endmodule

// ===== rtl/ldp_distort.sv =====
// Radial and tangential distortion of normalized coordinates, eleven register stages.
// Depends on ldp_pkg.
module ldp_distort (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_vld,
  input  ldp_pkg::div_out_t    din,
  input  ldp_pkg::q_t          k1,
  input  ldp_pkg::q_t          k2,
  input  ldp_pkg::q_t          p1,
  input  ldp_pkg::q_t          p2,
  output logic                 out_vld,
  output ldp_pkg::dist_out_t   dout
);

  logic [10:0] vld;

  ldp_pkg::q_t        xn1, yn1, xn2, yn2, xn3, yn3, xn4, yn4, xn5, yn5, xn6, yn6;
  ldp_pkg::q_t        xn7, yn7, xn8, yn8;
  ldp_pkg::meta_t     m1, m2, m3, m4, m5, m6, m7, m8, m9, m10;
  logic signed [63:0] pxy, pxx, pyy, pr4, pk1, pk2;
  ldp_pkg::q_t        xy2, xx2, yy2, xy3, xx3, yy3, r23;
  ldp_pkg::q_t        xy4, tx4, ty4, xy5, tx5, ty5, xy6, tx6, ty6, xy7, tx7, ty7;
  ldp_pkg::q_t        xy8, tx8, ty8;
  ldp_pkg::q_t        r45, k1r5, k1r6, k1r7, k2r7, rad8;
  logic signed [63:0] pa, pb, pc, pd, pe, pf;
  ldp_pkg::q_t        a10, b10, c10, d10, e10, f10;
  ldp_pkg::sat_t      s_xy, s_xx, s_yy, s_r2, s_tx, s_ty, s_r4, s_k1, s_k2, s_rad;
  ldp_pkg::sat_t      s_a, s_b, s_c, s_d, s_e, s_f, s_dx, s_dy;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[9:0], in_vld};
    end
  end
  assign out_vld = vld[10];

  // Rounding and saturation of every stage that needs it.
  always_comb begin
    s_xy  = ldp_pkg::rnd_sat(pxy);
    s_xx  = ldp_pkg::rnd_sat(pxx);
    s_yy  = ldp_pkg::rnd_sat(pyy);
    s_r2  = ldp_pkg::sat32(54'(xx2) + 54'(yy2));
    s_tx  = ldp_pkg::sat32(54'(r23) + 54'(xx3) + 54'(xx3));
    s_ty  = ldp_pkg::sat32(54'(r23) + 54'(yy3) + 54'(yy3));
    s_r4  = ldp_pkg::rnd_sat(pr4);
    s_k1  = ldp_pkg::rnd_sat(pk1);
    s_k2  = ldp_pkg::rnd_sat(pk2);
    s_rad = ldp_pkg::sat32(54'(ldp_pkg::Q_ONE) + 54'(k1r7) + 54'(k2r7));
    s_a   = ldp_pkg::rnd_sat(pa);
    s_b   = ldp_pkg::rnd_sat(pb);
    s_c   = ldp_pkg::rnd_sat(pc);
    s_d   = ldp_pkg::rnd_sat(pd);
    s_e   = ldp_pkg::rnd_sat(pe);
    s_f   = ldp_pkg::rnd_sat(pf);
    s_dx  = ldp_pkg::sat32(54'(a10) + 54'(b10) + 54'(b10) + 54'(c10));
    s_dy  = ldp_pkg::sat32(54'(d10) + 54'(e10) + 54'(e10) + 54'(f10));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage 1: cross and square products.
      pxy <= din.xn * din.yn;
      pxx <= din.xn * din.xn;
      pyy <= din.yn * din.yn;
      xn1 <= din.xn;
      yn1 <= din.yn;
      m1  <= din.meta;
      // Stage 2: round them back to Q4.28.
      xy2 <= s_xy.val;
      xx2 <= s_xx.val;
      yy2 <= s_yy.val;
      xn2 <= xn1;
      yn2 <= yn1;
      m2  <= {m1.ovf | s_xy.ovf | s_xx.ovf | s_yy.ovf, m1.zero, m1.sx, m1.sy};
      // Stage 3: squared radius.
      r23 <= s_r2.val;
      xy3 <= xy2;
      xx3 <= xx2;
      yy3 <= yy2;
      xn3 <= xn2;
      yn3 <= yn2;
      m3  <= {m2.ovf | s_r2.ovf, m2.zero, m2.sx, m2.sy};
      // Stage 4: r2 products and tangential radius terms.
      pr4 <= r23 * r23;
      pk1 <= k1 * r23;
      tx4 <= s_tx.val;
      ty4 <= s_ty.val;
      xy4 <= xy3;
      xn4 <= xn3;
      yn4 <= yn3;
      m4  <= {m3.ovf | s_tx.ovf | s_ty.ovf, m3.zero, m3.sx, m3.sy};
      // Stage 5: round r4 and k1*r2.
      r45  <= s_r4.val;
      k1r5 <= s_k1.val;
      xy5  <= xy4;
      tx5  <= tx4;
      ty5  <= ty4;
      xn5  <= xn4;
      yn5  <= yn4;
      m5   <= {m4.ovf | s_r4.ovf | s_k1.ovf, m4.zero, m4.sx, m4.sy};
      // Stage 6: k2*r4.
      pk2  <= k2 * r45;
      k1r6 <= k1r5;
      xy6  <= xy5;
      tx6  <= tx5;
      ty6  <= ty5;
      xn6  <= xn5;
      yn6  <= yn5;
      m6   <= m5;
      // Stage 7: round k2*r4.
      k2r7 <= s_k2.val;
      k1r7 <= k1r6;
      xy7  <= xy6;
      tx7  <= tx6;
      ty7  <= ty6;
      xn7  <= xn6;
      yn7  <= yn6;
      m7   <= {m6.ovf | s_k2.ovf, m6.zero, m6.sx, m6.sy};
      // Stage 8: radial factor.
      rad8 <= s_rad.val;
      xy8  <= xy7;
      tx8  <= tx7;
      ty8  <= ty7;
      xn8  <= xn7;
      yn8  <= yn7;
      m8   <= {m7.ovf | s_rad.ovf, m7.zero, m7.sx, m7.sy};
      // Stage 9: the six distortion products.
      pa <= xn8 * rad8;
      pb <= p1 * xy8;
      pc <= p2 * tx8;
      pd <= yn8 * rad8;
      pe <= p2 * xy8;
      pf <= p1 * ty8;
      m9 <= m8;
      // Stage 10: round them.
      a10 <= s_a.val;
      b10 <= s_b.val;
      c10 <= s_c.val;
      d10 <= s_d.val;
      e10 <= s_e.val;
      f10 <= s_f.val;
      m10 <= {m9.ovf | s_a.ovf | s_b.ovf | s_c.ovf | s_d.ovf | s_e.ovf | s_f.ovf,
              m9.zero, m9.sx, m9.sy};
      // Stage 11: distorted coordinates.
      dout.dx   <= s_dx.val;
      dout.dy   <= s_dy.val;
      dout.meta <= {m10.ovf | s_dx.ovf | s_dy.ovf, m10.zero, m10.sx, m10.sy};
    end
  end

endmodule

// ===== rtl/ldp_pixel.sv =====
// Camera matrix mapping of distorted coordinates to Q16.16 pixels, three stages.
// Depends on ldp_pkg; the last stage is the block's output register.
module ldp_pixel (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_vld,
  input  ldp_pkg::dist_out_t  din,
  input  logic [31:0]         fx,
  input  logic [31:0]         fy,
  input  logic [31:0]         cx,
  input  logic [31:0]         cy,
  output logic                out_vld,
  output ldp_pkg::q_t         pu,
  output ldp_pkg::q_t         pv,
  output logic                res_ok,
  output logic                zero
);

  logic [1:0]          vld;
  logic signed [64:0]  mu, mv;
  logic signed [64:0]  su, sv;
  logic signed [52:0]  ru, rv;
  ldp_pkg::meta_t      m1, m2;
  ldp_pkg::sat_t       s_u, s_v;

  assign su = mu + 65'sd2048;
  assign sv = mv + 65'sd2048;
  assign s_u = ldp_pkg::sat32(54'(ru) + 54'($signed({1'b0, cx})));
  assign s_v = ldp_pkg::sat32(54'(rv) + 54'($signed({1'b0, cy})));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else if (adv) begin
      vld     <= {vld[0], in_vld};
      out_vld <= vld[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage 1: focal length products.
      mu <= $signed({1'b0, fx}) * din.dx;
      mv <= $signed({1'b0, fy}) * din.dy;
      m1 <= din.meta;
      // Stage 2: round to 16 fraction bits.
      ru <= su[64:12];
      rv <= sv[64:12];
      m2 <= m1;
      // Stage 3: add the principal point; zero depth forces the rails.
      if (m2.zero) begin
        pu <= m2.sx ? ldp_pkg::S32_MIN : ldp_pkg::S32_MAX;
        pv <= m2.sy ? ldp_pkg::S32_MIN : ldp_pkg::S32_MAX;
      end else begin
        pu <= s_u.val;
        pv <= s_v.val;
      end
      res_ok <= !(m2.ovf | s_u.ovf | s_v.ovf);
      zero   <= m2.zero;
    end
  end

endmodule

// ===== rtl/lens_distortion_projection.sv =====
// An accepted transaction passes 34 divider, 11 distortion and 3 pixel mapping stages to its result;
// one transaction per cycle sustained while no valid output is stalled.
// The 32-stage bit-per-stage divider sets the depth; every stage holds while a valid output is stalled.
// Reset (synchronous, active high) clears all valid bits and loads the configuration
// registers with zero coefficients, focal lengths of 65536 and a zero principal point.
`include "lens_distortion_projection_macros.svh"

module lens_distortion_projection (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  world_x,
  input  logic signed [31:0]  world_y,
  input  logic signed [31:0]  world_z,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  pixel_u,
  output logic signed [31:0]  pixel_v,
  output logic                valid_res,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  ldp_pkg::q_t         radial_k1, radial_k2, tangential_p1, tangential_p2;
  logic [31:0]         focal_x, focal_y, center_x, center_y;
  logic                adv;
  logic                div_vld, dist_vld, zero;
  logic                u_rail, v_rail;
  ldp_pkg::div_out_t   div_out;
  ldp_pkg::dist_out_t  dist_out;

  // The whole pipeline moves unless a finished result is being held.
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      radial_k1     <= '0;
      radial_k2     <= '0;
      tangential_p1 <= '0;
      tangential_p2 <= '0;
      focal_x       <= 32'd65536;
      focal_y       <= 32'd65536;
      center_x      <= '0;
      center_y      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ldp_pkg::REG_K1: radial_k1     <= cfg_data;
        ldp_pkg::REG_K2: radial_k2     <= cfg_data;
        ldp_pkg::REG_P1: tangential_p1 <= cfg_data;
        ldp_pkg::REG_P2: tangential_p2 <= cfg_data;
        ldp_pkg::REG_FX: focal_x       <= cfg_data;
        ldp_pkg::REG_FY: focal_y       <= cfg_data;
        ldp_pkg::REG_CX: center_x      <= cfg_data;
        ldp_pkg::REG_CY: center_y      <= cfg_data;
      endcase
    end
  end

  ldp_divider u_div (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (in_valid),
    .wx      (world_x),
    .wy      (world_y),
    .wz      (world_z),
    .out_vld (div_vld),
    .dout    (div_out)
  );

  ldp_distort u_dist (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (div_vld),
    .din     (div_out),
    .k1      (radial_k1),
    .k2      (radial_k2),
    .p1      (tangential_p1),
    .p2      (tangential_p2),
    .out_vld (dist_vld),
    .dout    (dist_out)
  );

  ldp_pixel u_pix (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (dist_vld),
    .din     (dist_out),
    .fx      (focal_x),
    .fy      (focal_y),
    .cx      (center_x),
    .cy      (center_y),
    .out_vld (out_valid),
    .pu      (pixel_u),
    .pv      (pixel_v),
    .res_ok  (valid_res),
    .zero    (zero)
  );

  // Flags for a coordinate that sits on one of its two rails.
  assign u_rail = (pixel_u == ldp_pkg::S32_MAX) || (pixel_u == ldp_pkg::S32_MIN);
  assign v_rail = (pixel_v == ldp_pkg::S32_MAX) || (pixel_v == ldp_pkg::S32_MIN);

  // A zero-depth ray is never reported as a good projection.
  `LDP_ASSERT_IMP(a_zero_invalid, out_valid && zero, !valid_res)
  // A zero-depth ray lands on a rail in both coordinates.
  `LDP_ASSERT_IMP(a_zero_rail, out_valid && zero, u_rail && v_rail)
  // A focal length write takes effect on the next cycle.
  `LDP_ASSERT_NXT(a_cfg_fx, cfg_valid && cfg_index == ldp_pkg::REG_FX, focal_x == $past(cfg_data))

endmodule
